/* sv/tsb_pkg.sv */
package tsb_pkg;

    localparam logic [1:0] K_WRITE = 2'd0;
    localparam logic [1:0] K_NEAR  = 2'd1;
    localparam logic [1:0] K_BILIN = 2'd2;

    localparam logic [1:0] CFG_TEX_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_TEX_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_FILTER_MODE  = 2'd2;
    localparam logic [1:0] CFG_ADDRESS_MODE = 2'd3;

    localparam logic [1:0] AM_WRAP   = 2'd0;
    localparam logic [1:0] AM_MIRROR = 2'd1;

    localparam int WT_W  = 17;
    localparam int ACC_W = 25;

    typedef struct packed {
        logic [6:0] size_x;
        logic [6:0] size_y;
        logic       bilinear;
        logic [1:0] amode;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            kind;
        logic [6:0]            x0;
        logic [6:0]            x1;
        logic [6:0]            y0;
        logic [6:0]            y1;
        logic [3:0][WT_W-1:0]  wt;
        logic [31:0]           data;
    } t_cmd;

endpackage

/* sv/texture_sampler_bilinear.sv */
// Texture sampler over an on-chip MAX_SIZE x MAX_SIZE RGBA8 texel store. Raise start while
// busy is low to hand over a transaction: op 0 writes one texel, op 1 samples at u,v. A
// sample answers with one o_strobe cycle carrying the four channels; the receiver must take
// it then, as the block cannot be held off. The front end stays busy until it pushes the
// transaction into the queue, also while that is full; a sample first passes its bit-serial
// coordinate remainder unit (11 steps per sample). Behind a 2-entry queue, the back end reads
// one texel per cycle from the single-port store: four for bilinear, one for nearest sampling.
// Results come out in the order of the transactions. The store is not cleared at reset.
module texture_sampler_bilinear #(
    parameter int MAX_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [6:0]  i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [19:0] i_u_coord,
    input  logic [19:0] i_v_coord,
    input  logic [5:0]  i_texel_col,
    input  logic [5:0]  i_texel_row,
    input  logic [31:0] i_texel_value,
    output logic        o_strobe,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha
);
    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [6:0]    r_tex_width;
    logic [6:0]    r_tex_height;
    logic          r_filter_mode;
    logic [1:0]    r_address_mode;
    tsb_pkg::t_cfg cfg;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    tsb_pkg::t_cmd q_in;
    tsb_pkg::t_cmd q_out;
    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_rdata;

    function automatic logic [6:0] eff_size(input logic [6:0] r);
        if (r == 7'd0) begin
            return 7'd1;
        end else if (int'(r) > MAX_SIZE) begin
            return 7'(MAX_SIZE);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width    <= 7'd64;
            r_tex_height   <= 7'd64;
            r_filter_mode  <= 1'b1;
            r_address_mode <= tsb_pkg::AM_WRAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tsb_pkg::CFG_TEX_WIDTH:    r_tex_width    <= i_cfg_data;
                tsb_pkg::CFG_TEX_HEIGHT:   r_tex_height   <= i_cfg_data;
                tsb_pkg::CFG_FILTER_MODE:  r_filter_mode  <= i_cfg_data[0];
                tsb_pkg::CFG_ADDRESS_MODE: r_address_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign cfg.size_x   = eff_size(r_tex_width);
    assign cfg.size_y   = eff_size(r_tex_height);
    assign cfg.bilinear = r_filter_mode;
    assign cfg.amode    = r_address_mode;

    tsb_front #(.MAX_SIZE(MAX_SIZE)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_start       (start),
        .i_op          (i_op),
        .i_u_coord     (i_u_coord),
        .i_v_coord     (i_v_coord),
        .i_texel_col   (i_texel_col),
        .i_texel_row   (i_texel_row),
        .i_texel_value (i_texel_value),
        .o_busy        (busy),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    tsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tsb_back #(.MAX_SIZE(MAX_SIZE), .ADDR_W(ADDR_W)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (q_out),
        .o_pop       (q_pop),
        .o_ram_en    (ram_en),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_strobe    (o_strobe),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha     (o_alpha)
    );

    tsb_ram #(.WIDTH(32), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full && !q_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held over two cycles");

endmodule

/* sv/tsb_ram.sv */
module tsb_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/tsb_queue.sv */
module tsb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsb_pkg::t_cmd i_data,
    input  logic          i_pop,
    output tsb_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);
    tsb_pkg::t_cmd r_slot [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    assign o_data  = r_slot[r_rd];
    assign o_full  = r_cnt[1];
    assign o_empty = (r_cnt == 2'd0);
endmodule

/* sv/tsb_front.sv */
module tsb_front #(
    parameter int MAX_SIZE = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tsb_pkg::t_cfg i_cfg,
    input  logic          i_start,
    input  logic          i_op,
    input  logic [19:0]   i_u_coord,
    input  logic [19:0]   i_v_coord,
    input  logic [5:0]    i_texel_col,
    input  logic [5:0]    i_texel_row,
    input  logic [31:0]   i_texel_value,
    output logic          o_busy,
    input  logic          i_full,
    output logic          o_push,
    output tsb_pkg::t_cmd o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;
    localparam logic [3:0] LAST_BIT = 4'd10;

    logic [1:0]         r_state;
    logic [3:0]         r_cnt;
    logic signed [19:0] r_u;
    logic signed [19:0] r_v;
    logic signed [26:0] r_su;
    logic signed [26:0] r_sv;
    logic [7:0]         r_rx;
    logic [7:0]         r_ry;
    tsb_pkg::t_cmd      r_wcmd;
    logic               r_is_write;

    logic [7:0]         mod_x;
    logic [7:0]         mod_y;
    logic signed [10:0] nx;
    logic signed [10:0] ny;
    logic [10:0]        mag_x;
    logic [10:0]        mag_y;
    logic [7:0]         n_rx;
    logic [7:0]         n_ry;
    tsb_pkg::t_cmd      scmd;

    function automatic logic [7:0] rem_step(input logic [7:0] rem, input logic b,
                                            input logic [7:0] m);
        logic [8:0] t;
        t = {rem, b};
        return (t >= {1'b0, m}) ? 8'(t - {1'b0, m}) : t[7:0];
    endfunction

    function automatic logic [7:0] fix_neg(input logic [7:0] r, input logic neg,
                                           input logic [7:0] m);
        return (neg && r != 8'd0) ? m - r : r;
    endfunction

    function automatic logic [7:0] inc_mod(input logic [7:0] r, input logic [7:0] m);
        return (r + 8'd1 == m) ? 8'd0 : r + 8'd1;
    endfunction

    function automatic logic [6:0] fold(input logic [7:0] m, input logic [6:0] s);
        return (m < {1'b0, s}) ? m[6:0] : 7'({s, 1'b0} - 8'd1 - m);
    endfunction

    function automatic logic [6:0] clamp(input logic signed [11:0] n, input logic [6:0] s);
        if (n < 0) begin
            return 7'd0;
        end else if (n >= $signed({5'b0, s})) begin
            return s - 7'd1;
        end
        return n[6:0];
    endfunction

    function automatic logic [13:0] axis(input logic signed [10:0] n, input logic [7:0] r,
                                         input logic [6:0] s, input logic [1:0] am);
        logic [7:0]         m;
        logic [7:0]         r1;
        logic signed [11:0] n0;
        m  = (am == tsb_pkg::AM_MIRROR) ? {s, 1'b0} : {1'b0, s};
        r1 = inc_mod(r, m);
        n0 = {n[10], n};
        unique case (am)
            tsb_pkg::AM_WRAP:   return {r1[6:0], r[6:0]};
            tsb_pkg::AM_MIRROR: return {fold(r1, s), fold(r, s)};
            default:            return {clamp(n0 + 12'sd1, s), clamp(n0, s)};
        endcase
    endfunction

    function automatic logic [tsb_pkg::WT_W-1:0] wmul(input logic [8:0] a, input logic [8:0] b);
        logic [17:0] p;
        p = a * b;
        return p[tsb_pkg::WT_W-1:0];
    endfunction

    assign nx    = r_su[26:16];
    assign ny    = r_sv[26:16];
    assign mag_x = nx[10] ? 11'(-nx) : 11'(nx);
    assign mag_y = ny[10] ? 11'(-ny) : 11'(ny);
    assign mod_x = (i_cfg.amode == tsb_pkg::AM_MIRROR) ? {i_cfg.size_x, 1'b0}
                                                       : {1'b0, i_cfg.size_x};
    assign mod_y = (i_cfg.amode == tsb_pkg::AM_MIRROR) ? {i_cfg.size_y, 1'b0}
                                                       : {1'b0, i_cfg.size_y};
    assign n_rx  = rem_step(r_rx, mag_x[LAST_BIT - r_cnt], mod_x);
    assign n_ry  = rem_step(r_ry, mag_y[LAST_BIT - r_cnt], mod_y);

    always_comb begin
        logic [8:0]  fx;
        logic [8:0]  fy;
        logic [13:0] ax;
        logic [13:0] ay;
        fx = {1'b0, r_su[15:8]};
        fy = {1'b0, r_sv[15:8]};
        ax = axis(nx, fix_neg(r_rx, nx[10], mod_x), i_cfg.size_x, i_cfg.amode);
        ay = axis(ny, fix_neg(r_ry, ny[10], mod_y), i_cfg.size_y, i_cfg.amode);
        scmd.kind  = i_cfg.bilinear ? tsb_pkg::K_BILIN : tsb_pkg::K_NEAR;
        scmd.x0    = ax[6:0];
        scmd.x1    = ax[13:7];
        scmd.y0    = ay[6:0];
        scmd.y1    = ay[13:7];
        scmd.wt[0] = wmul(9'd256 - fx, 9'd256 - fy);
        scmd.wt[1] = wmul(fx, 9'd256 - fy);
        scmd.wt[2] = wmul(9'd256 - fx, fy);
        scmd.wt[3] = wmul(fx, fy);
        scmd.data  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 4'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (!i_op) begin
                            // drop writes that fall outside the store
                            if (int'(i_texel_col) < MAX_SIZE && int'(i_texel_row) < MAX_SIZE)
                            begin
                                r_state <= S_PUSH;
                            end
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_cnt   <= 4'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == LAST_BIT) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_is_write    <= !i_op;
            r_u           <= i_u_coord;
            r_v           <= i_v_coord;
            r_wcmd.kind   <= tsb_pkg::K_WRITE;
            r_wcmd.x0     <= {1'b0, i_texel_col};
            r_wcmd.y0     <= {1'b0, i_texel_row};
            r_wcmd.x1     <= '0;
            r_wcmd.y1     <= '0;
            r_wcmd.wt     <= '0;
            r_wcmd.data   <= i_texel_value;
        end
        if (r_state == S_MUL) begin
            // step back half a texel before flooring when filtering
            r_su <= 27'(r_u * $signed({1'b0, i_cfg.size_x}))
                    - (i_cfg.bilinear ? 27'sd32768 : 27'sd0);
            r_sv <= 27'(r_v * $signed({1'b0, i_cfg.size_y}))
                    - (i_cfg.bilinear ? 27'sd32768 : 27'sd0);
            r_rx <= 8'd0;
            r_ry <= 8'd0;
        end
        if (r_state == S_DIV) begin
            r_rx <= n_rx;
            r_ry <= n_ry;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_cmd  = r_is_write ? r_wcmd : scmd;
endmodule

/* sv/tsb_back.sv */
module tsb_back #(
    parameter int MAX_SIZE = 64,
    parameter int ADDR_W   = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  tsb_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output logic              o_ram_en,
    output logic              o_ram_we,
    output logic [ADDR_W-1:0] o_ram_addr,
    output logic [31:0]       o_ram_wdata,
    input  logic [31:0]       i_ram_rdata,
    output logic              o_strobe,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_alpha
);
    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_LAST = 2'd2;

    logic [1:0]                     r_state;
    logic [1:0]                     r_k;
    tsb_pkg::t_cmd                  r_cmd;
    logic [3:0][tsb_pkg::ACC_W-1:0] r_acc;
    logic                           r_strobe;
    logic [3:0][7:0]                r_out;
    logic [6:0]                     rx;
    logic [6:0]                     ry;
    logic [3:0][tsb_pkg::ACC_W-1:0] sum;
    logic [tsb_pkg::WT_W-1:0]       wsel;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [6:0] x, input logic [6:0] y);
        return ADDR_W'(int'(y) * MAX_SIZE + int'(x));
    endfunction

    assign rx   = r_k[0] ? r_cmd.x1 : r_cmd.x0;
    assign ry   = r_k[1] ? r_cmd.y1 : r_cmd.y0;
    assign wsel = (r_state == B_LAST) ? r_cmd.wt[3] : r_cmd.wt[r_k - 2'd1];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum[c] = r_acc[c] + tsb_pkg::ACC_W'(i_ram_rdata[8*c +: 8] * wsel);
        end
    end

    assign o_pop = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        o_ram_en    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = addr_of(rx, ry);
        o_ram_wdata = i_cmd.data;
        if (o_pop && i_cmd.kind == tsb_pkg::K_WRITE) begin
            o_ram_en   = 1'b1;
            o_ram_we   = 1'b1;
            o_ram_addr = addr_of(i_cmd.x0, i_cmd.y0);
        end else if (r_state == B_RD) begin
            o_ram_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_strobe <= 1'b0;
            r_k      <= 2'd0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    r_k <= 2'd0;
                    if (o_pop && i_cmd.kind != tsb_pkg::K_WRITE) begin
                        r_state <= B_RD;
                    end
                end
                B_RD: begin
                    r_k <= r_k + 2'd1;
                    if (r_cmd.kind == tsb_pkg::K_NEAR || r_k == 2'd3) begin
                        r_state <= B_LAST;
                    end
                end
                B_LAST: begin
                    r_strobe <= 1'b1;
                    r_state  <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            for (int c = 0; c < 4; c++) begin
                r_acc[c] <= tsb_pkg::ACC_W'(32768);
            end
        end
        if (r_state == B_RD && r_k != 2'd0) begin
            r_acc <= sum;
        end
        if (r_state == B_LAST) begin
            for (int c = 0; c < 4; c++) begin
                r_out[c] <= (r_cmd.kind == tsb_pkg::K_NEAR) ? i_ram_rdata[8*c +: 8]
                                                            : sum[c][23:16];
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_red    = r_out[0];
    assign o_green  = r_out[1];
    assign o_blue   = r_out[2];
    assign o_alpha  = r_out[3];
endmodule
